FILE: src/metric_line_label_parser_macros.svh
// assertion helpers for the metric line label parser
`ifndef METRIC_LINE_LABEL_PARSER_MACROS_SVH
`define METRIC_LINE_LABEL_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MLLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MLLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mllp_pkg.sv
`timescale 1ns / 1ps

package mllp_pkg;

  // parser modes
  localparam logic [2:0] MODE_KEY   = 3'd0;
  localparam logic [2:0] MODE_LABEL = 3'd1;
  localparam logic [2:0] MODE_AFTER = 3'd2;
  localparam logic [2:0] MODE_VALUE = 3'd3;
  localparam logic [2:0] MODE_ERR1  = 3'd4;
  localparam logic [2:0] MODE_ERR2  = 3'd5;
  localparam logic [2:0] MODE_ERR3  = 3'd6;

  // byte roles
  typedef enum logic [3:0] {
    CLS_KEY      = 4'd0,
    CLS_KEYDELIM = 4'd1,
    CLS_LNAME    = 4'd2,
    CLS_LSPLIT   = 4'd3,
    CLS_LVALUE   = 4'd4,
    CLS_LDELIM   = 4'd5,
    CLS_SEP      = 4'd6,
    CLS_VALUE    = 4'd7,
    CLS_IGNORED  = 4'd8,
    CLS_END      = 4'd9
  } byte_class_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_KEY_EQUAL  = 2'd1,
    ERR_AFTER_LBL  = 2'd2,
    ERR_BAD_LABEL  = 2'd3
  } err_e;

  // delimiter bytes
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_EQUAL  = 8'h3D;  // '='
  localparam logic [7:0] CH_NUL    = 8'h00;

  // one tagged result
  typedef struct packed {
    byte_class_e byte_class;
    err_e        err;
    logic [7:0]  ch_echo;
    logic        line_done;
  } result_t;

endpackage

FILE: src/metric_line_label_parser.sv
`timescale 1ns / 1ps
// channel      | direction | tdata         | tuser                        | tlast
// -------------+-----------+---------------+------------------------------+----------
// s_axis (in)  | input     | [7:0] ch      | -                            | at_end
// m_axis (out) | output    | [7:0] ch_echo | [3:0] byte_class, [5:4] err  | line_done
//
// one transfer in gives exactly one transfer out, registered and offered in the cycle after acceptance
// sustained rate is one byte per clock while every result is taken, set by the single result register
// the input side stalls only when the result register is full and not taken
// async active-low reset returns the parser to key mode with an empty output
// the mode / label flags update in the same cycle an item is accepted

`include "metric_line_label_parser_macros.svh"

module metric_line_label_parser
  import mllp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] ch
  input  logic       s_axis_tlast_i,   // at_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] ch_echo
  output logic [5:0] m_axis_tuser_o,   // [3:0] byte_class, [5:4] err
  output logic       m_axis_tlast_o    // line_done
);

  // parser state
  logic [2:0] mode_q, mode_d;
  logic       eq_seen_q, eq_seen_d;       // current label has had its '='
  logic       after_eq_q, after_eq_d;     // a byte followed that '='

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic accept;
  logic [7:0] ch;
  logic       label_ok;
  logic       label_end;

  // the result register frees up when empty or when being taken this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign ch        = s_axis_tdata_i;
  assign label_ok  = eq_seen_q && after_eq_q;
  assign label_end = (ch == CH_RBRACK) || (ch == CH_COLON) || (ch == CH_NUL);

  // next state and result for the byte on the input
  always_comb begin
    mode_d             = mode_q;
    eq_seen_d          = eq_seen_q;
    after_eq_d         = after_eq_q;
    res_d.byte_class   = CLS_IGNORED;
    res_d.err          = ERR_NONE;
    res_d.ch_echo      = ch;
    res_d.line_done    = 1'b0;

    if (s_axis_tlast_i) begin
      // end of line: report what is pending, then back to key mode
      case (mode_q)
        MODE_ERR1:  res_d.err = ERR_KEY_EQUAL;
        MODE_ERR2:  res_d.err = ERR_AFTER_LBL;
        MODE_ERR3:  res_d.err = ERR_BAD_LABEL;
        MODE_LABEL: res_d.err = label_ok ? ERR_NONE : ERR_BAD_LABEL;
        MODE_AFTER: res_d.err = ERR_AFTER_LBL;
        default:    res_d.err = ERR_NONE;
      endcase
      res_d.byte_class = CLS_END;
      res_d.ch_echo    = '0;
      res_d.line_done  = 1'b1;
      mode_d           = MODE_KEY;
      eq_seen_d        = 1'b0;
      after_eq_d       = 1'b0;
    end else begin
      case (mode_q)
        MODE_LABEL: begin
          if (label_end) begin
            if (label_ok) begin
              res_d.byte_class = CLS_LDELIM;
              mode_d           = MODE_AFTER;
            end else begin
              res_d.err = ERR_BAD_LABEL;
              mode_d    = MODE_ERR3;
            end
            eq_seen_d  = 1'b0;
            after_eq_d = 1'b0;
          end else if ((ch == CH_EQUAL) && !eq_seen_q) begin
            res_d.byte_class = CLS_LSPLIT;
            eq_seen_d        = 1'b1;
          end else if (eq_seen_q) begin
            res_d.byte_class = CLS_LVALUE;
            after_eq_d       = 1'b1;
          end else begin
            res_d.byte_class = CLS_LNAME;
          end
        end
        MODE_AFTER: begin
          if (ch == CH_LBRACK) begin
            res_d.byte_class = CLS_LDELIM;
            mode_d           = MODE_LABEL;
            eq_seen_d        = 1'b0;
            after_eq_d       = 1'b0;
          end else if (ch == CH_COLON) begin
            res_d.byte_class = CLS_SEP;
            mode_d           = MODE_VALUE;
          end else begin
            res_d.err = ERR_AFTER_LBL;
            mode_d    = MODE_ERR2;
          end
        end
        MODE_VALUE: res_d.byte_class = CLS_VALUE;
        // sticky errors repeat their code
        MODE_ERR1:  res_d.err = ERR_KEY_EQUAL;
        MODE_ERR2:  res_d.err = ERR_AFTER_LBL;
        MODE_ERR3:  res_d.err = ERR_BAD_LABEL;
        default: begin
          // key mode, and the unused code behaves the same
          if (ch == CH_LBRACK) begin
            res_d.byte_class = CLS_KEYDELIM;
            mode_d           = MODE_LABEL;
            eq_seen_d        = 1'b0;
            after_eq_d       = 1'b0;
          end else if ((ch == CH_COLON) || (ch == CH_NUL)) begin
            res_d.byte_class = CLS_KEYDELIM;
            mode_d           = MODE_VALUE;
          end else if (ch == CH_EQUAL) begin
            res_d.err = ERR_KEY_EQUAL;
            mode_d    = MODE_ERR1;
          end else begin
            res_d.byte_class = CLS_KEY;
            mode_d           = MODE_KEY;
          end
        end
      endcase
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_KEY;
      eq_seen_q   <= 1'b0;
      after_eq_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q     <= mode_d;
        eq_seen_q  <= eq_seen_d;
        after_eq_q <= after_eq_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q.ch_echo;
  assign m_axis_tuser_o  = {res_q.err, res_q.byte_class};
  assign m_axis_tlast_o  = res_q.line_done;

  // an end transfer always leaves the parser in key mode with a clean label
  `MLLP_ASSERT_NEXT(a_end_resets, accept && s_axis_tlast_i, (mode_q == MODE_KEY) && !eq_seen_q && !after_eq_q, "parser not reset after end transfer")

  // the end flag and the end class travel together
  `MLLP_ASSERT_NOW(a_end_class, m_axis_tvalid_o, m_axis_tlast_o == (m_axis_tuser_o[3:0] == CLS_END), "line_done and end class disagree")

  // an error code only rides on ignored or end bytes
  `MLLP_ASSERT_NOW(a_err_class, m_axis_tvalid_o && (m_axis_tuser_o[5:4] != ERR_NONE), (m_axis_tuser_o[3:0] == CLS_IGNORED) || (m_axis_tuser_o[3:0] == CLS_END), "error code on a tagged byte")

endmodule
